@@ rtl/rfw_pkg.sv @@
// ----------------------------------------------------------------------------
// rfw_pkg
// Shared constants for the reed flow waveshaper: fixed-point scales,
// filter and area coefficients, and the step counts of the iterative units.
// ----------------------------------------------------------------------------
`default_nettype none

package rfw_pkg;

    // Q4.20 and Q2.30 unity
    localparam logic [31:0] Q20_ONE   = 32'd1048576;
    localparam logic [31:0] Q30_ONE   = 32'd1073741824;

    // smoother and area coefficients in Q4.20
    localparam logic [31:0] K_SMOOTH  = 32'd996147;
    localparam logic [31:0] K_FEED    = 32'd52429;
    localparam logic [31:0] K_OPEN    = 32'd734003;

    // ceil(2^21 / 3), exact floor division by 3 below 2^21
    localparam logic [31:0] RECIP3    = 32'd699051;
    localparam int          RECIP3_SH = 21;

    // 2|x| clamp, 16.0 in Q4.20
    localparam logic [24:0] Y_CLAMP   = 25'd16777216;

    // register index decoded from paddr[2]
    localparam logic        REG_INTENSITY = 1'b0;

    // integer square root of area * 2^20
    localparam int          ISQ_RAD_W  = 44;
    localparam int          ISQ_ROOT_W = 22;
    localparam int          ISQ_STEPS  = 22;

    localparam int          SQ_STEPS   = 8;
    localparam int          DIV_STEPS  = 16;

endpackage

`default_nettype wire

@@ rtl/reed_flow_waveshaper.sv @@
// ----------------------------------------------------------------------------
// reed_flow_waveshaper
// Reed flow model: smoothed reed opening, flow through the open area and a
// tanh output shaper, all run on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
//  channel   signals                                   width  dir
//  config    psel penable pwrite paddr pwdata prdata    32     in/out
//  input     in_valid in_ready pressure_in              16     in
//  output    out_valid out_ready shaped_out             16     out
//
//  a closed reed skips the 22-step square root, the 8 squarings and the
//  16-step divide and goes from the area check straight to the output
//  in_ready is high only in idle; one item is worked on at a time
//  a finished result waits in the output register while the next item runs
//  reset clears the reed opening and loads intensity with 0.5
// ----------------------------------------------------------------------------
`default_nettype none

module reed_flow_waveshaper (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] pressure_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] shaped_out
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_M_SMOOTH, ST_M_FEED, ST_M_OPEN, ST_OPEN, ST_AREA, ST_SQRT,
        ST_M_FLOW, ST_FLOW, ST_M_X, ST_X, ST_U, ST_M_U2, ST_U2, ST_M_U3, ST_U3,
        ST_M_U4, ST_U4, ST_D6, ST_E, ST_M_SQ, ST_SQ, ST_DIV_INIT, ST_DIV, ST_OUT
    } state_t;

    function automatic logic signed [63:0] rnd20(input logic signed [63:0] v);
        logic signed [63:0] adj;
        // round half away from zero
        adj = v[63] ? 64'sd524287 : 64'sd524288;
        return (v + adj) >>> 20;
    endfunction

    state_t                 state_reg,    state_next;
    logic [15:0]            intensity_reg, intensity_next;
    logic signed [23:0]     opening_reg,  opening_next;
    logic                   out_valid_reg, out_valid_next;
    logic [3:0]             cnt_reg,      cnt_next;

    logic signed [15:0]     shaped_reg,   shaped_next;
    logic signed [19:0]     pres_reg,     pres_next;
    logic signed [63:0]     prod_reg;
    logic signed [45:0]     acc_reg,      acc_next;
    logic [20:0]            kopen_reg,    kopen_next;
    logic signed [22:0]     flow_reg,     flow_next;
    logic signed [23:0]     x_reg,        x_next;
    logic                   neg_reg,      neg_next;
    logic [26:0]            u_reg,        u_next;
    logic [22:0]            u2_reg,       u2_next;
    logic [18:0]            u3_reg,       u3_next;
    logic [14:0]            u4_reg,       u4_next;
    logic [17:0]            d6_reg,       d6_next;
    logic [30:0]            e_reg,        e_next;
    logic [47:0]            rem_reg,      rem_next;
    logic [47:0]            dsh_reg,      dsh_next;
    logic [15:0]            q_reg,        q_next;

    logic signed [31:0]     mul_a;
    logic signed [31:0]     mul_b;
    logic signed [63:0]     mul_p;

    logic [20:0]            inten_w;
    logic [21:0]            opi_w;
    logic signed [63:0]     acc_rnd;
    logic signed [63:0]     prod_rnd20;
    logic signed [63:0]     prod_rnd30;
    logic signed [25:0]     area_w;
    logic [23:0]            ax_w;
    logic [24:0]            y_w;
    logic [30:0]            ec_w;
    logic [30:0]            num_w;
    logic [31:0]            den_w;

    logic                                  sq_start;
    logic                                  sq_done;
    logic [rfw_pkg::ISQ_ROOT_W-1:0]        sq_root;
    logic                                  cfg_wr;

    rfw_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ({area_w[23:0], 20'd0}),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign mul_p      = mul_a * mul_b;
    assign inten_w    = {intensity_reg, 5'd0};
    assign opi_w      = 22'(rfw_pkg::Q20_ONE) + 22'(inten_w);
    assign acc_rnd    = rnd20(64'(acc_reg));
    assign prod_rnd20 = rnd20(prod_reg);
    assign prod_rnd30 = (prod_reg + 64'sd536870912) >>> 30;
    assign area_w     = $signed(26'(rfw_pkg::Q20_ONE) + {{2{opening_reg[23]}}, opening_reg}
                                - {5'd0, kopen_reg});
    assign ax_w       = x_reg[23] ? 24'(-x_reg) : 24'(x_reg);
    assign y_w        = ({ax_w, 1'b0} > rfw_pkg::Y_CLAMP) ? rfw_pkg::Y_CLAMP : {ax_w, 1'b0};
    assign ec_w       = (32'(e_reg) > rfw_pkg::Q30_ONE) ? 31'(rfw_pkg::Q30_ONE) : e_reg;
    assign num_w      = 31'(rfw_pkg::Q30_ONE - 32'(ec_w));
    assign den_w      = rfw_pkg::Q30_ONE + 32'(ec_w);

    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == rfw_pkg::REG_INTENSITY);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == rfw_pkg::REG_INTENSITY) ? {16'd0, intensity_reg} : 32'd0;
    assign sq_start = (state_reg == ST_AREA) && (area_w > 26'sd0);

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign shaped_out = shaped_reg;

    always_comb
    begin
        state_next     = state_reg;
        intensity_next = cfg_wr ? pwdata[15:0] : intensity_reg;
        opening_next   = opening_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cnt_next       = cnt_reg;
        shaped_next    = shaped_reg;
        pres_next      = pres_reg;
        acc_next       = acc_reg;
        kopen_next     = kopen_reg;
        flow_next      = flow_reg;
        x_next         = x_reg;
        neg_next       = neg_reg;
        u_next         = u_reg;
        u2_next        = u2_reg;
        u3_next        = u3_reg;
        u4_next        = u4_reg;
        d6_next        = d6_reg;
        e_next         = e_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pres_next  = {pressure_in, 4'd0};
                    state_next = ST_M_SMOOTH;
                end
            end
            ST_M_SMOOTH:
            begin
                mul_a      = 32'(opening_reg);
                mul_b      = rfw_pkg::K_SMOOTH;
                state_next = ST_M_FEED;
            end
            ST_M_FEED:
            begin
                mul_a      = 32'(pres_reg);
                mul_b      = rfw_pkg::K_FEED;
                acc_next   = prod_reg[45:0];
                state_next = ST_M_OPEN;
            end
            ST_M_OPEN:
            begin
                mul_a      = 32'(inten_w);
                mul_b      = rfw_pkg::K_OPEN;
                acc_next   = acc_reg + prod_reg[45:0];
                state_next = ST_OPEN;
            end
            ST_OPEN:
            begin
                if (acc_rnd > 64'sd8388607)
                    opening_next = 24'sh7FFFFF;
                else if (acc_rnd < -64'sd8388608)
                    opening_next = 24'sh800000;
                else
                    opening_next = acc_rnd[23:0];
                kopen_next = prod_rnd20[20:0];
                state_next = ST_AREA;
            end
            ST_AREA:
            begin
                if (area_w > 26'sd0)
                    state_next = ST_SQRT;
                else
                begin
                    // closed reed: flow is zero, so is the output
                    q_next     = '0;
                    neg_next   = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_SQRT:
            begin
                if (sq_done)
                    state_next = ST_M_FLOW;
            end
            ST_M_FLOW:
            begin
                mul_a      = 32'(pres_reg);
                mul_b      = 32'(sq_root);
                state_next = ST_FLOW;
            end
            ST_FLOW:
            begin
                flow_next  = prod_rnd20[22:0];
                state_next = ST_M_X;
            end
            ST_M_X:
            begin
                mul_a      = 32'(flow_reg);
                mul_b      = 32'(opi_w);
                state_next = ST_X;
            end
            ST_X:
            begin
                x_next     = prod_rnd20[23:0];
                state_next = ST_U;
            end
            ST_U:
            begin
                neg_next   = x_reg[23];
                // 2|x| / 256 in Q2.30
                u_next     = {y_w, 2'b00};
                state_next = ST_M_U2;
            end
            ST_M_U2:
            begin
                mul_a      = 32'(u_reg);
                mul_b      = 32'(u_reg);
                state_next = ST_U2;
            end
            ST_U2:
            begin
                u2_next    = prod_rnd30[22:0];
                state_next = ST_M_U3;
            end
            ST_M_U3:
            begin
                mul_a      = 32'(u2_reg);
                mul_b      = 32'(u_reg);
                state_next = ST_U3;
            end
            ST_U3:
            begin
                u3_next    = prod_rnd30[18:0];
                state_next = ST_M_U4;
            end
            ST_M_U4:
            begin
                mul_a      = 32'(u3_reg);
                mul_b      = 32'(u_reg);
                state_next = ST_U4;
            end
            ST_U4:
            begin
                u4_next    = prod_rnd30[14:0];
                // u3/6 as (u3/2)/3
                mul_a      = 32'(u3_reg[18:1]);
                mul_b      = rfw_pkg::RECIP3;
                state_next = ST_D6;
            end
            ST_D6:
            begin
                d6_next    = prod_reg[rfw_pkg::RECIP3_SH+17:rfw_pkg::RECIP3_SH];
                // u4/24 as (u4/8)/3
                mul_a      = 32'(u4_reg[14:3]);
                mul_b      = rfw_pkg::RECIP3;
                state_next = ST_E;
            end
            ST_E:
            begin
                e_next     = 31'(rfw_pkg::Q30_ONE + 32'(u2_reg[22:1])
                                 + 32'(prod_reg[rfw_pkg::RECIP3_SH+10:rfw_pkg::RECIP3_SH])
                                 - 32'(u_reg) - 32'(d6_reg));
                cnt_next   = '0;
                state_next = ST_M_SQ;
            end
            ST_M_SQ:
            begin
                mul_a      = 32'(e_reg);
                mul_b      = 32'(e_reg);
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                e_next   = prod_rnd30[30:0];
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(rfw_pkg::SQ_STEPS - 1))
                    state_next = ST_DIV_INIT;
                else
                    state_next = ST_M_SQ;
            end
            ST_DIV_INIT:
            begin
                // (num * 2^16 + den) / (2 * den), divisor pre-shifted
                rem_next   = 48'({num_w, 16'd0}) + 48'(den_w);
                dsh_next   = 48'({den_w, 16'd0});
                q_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[14:0], 1'b1};
                end
                else
                    q_next   = {q_reg[14:0], 1'b0};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(rfw_pkg::DIV_STEPS - 1))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                        shaped_next = $signed(16'(17'd0 - {1'b0, q_reg}));
                    else if (q_reg > 16'd32767)
                        shaped_next = 16'sh7FFF;
                    else
                        shaped_next = $signed(q_reg);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            intensity_reg <= 16'd16384;
            opening_reg   <= '0;
            out_valid_reg <= 1'b0;
            shaped_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            intensity_reg <= intensity_next;
            opening_reg   <= opening_next;
            out_valid_reg <= out_valid_next;
            shaped_reg    <= shaped_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= mul_p;
        pres_reg   <= pres_next;
        acc_reg    <= acc_next;
        kopen_reg  <= kopen_next;
        flow_reg   <= flow_next;
        x_reg      <= x_next;
        neg_reg    <= neg_next;
        u_reg      <= u_next;
        u2_reg     <= u2_next;
        u3_reg     <= u3_next;
        u4_reg     <= u4_next;
        d6_reg     <= d6_next;
        e_reg      <= e_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        q_reg      <= q_next;
    end

endmodule

`default_nettype wire

@@ rtl/rfw_isqrt.sv @@
// ----------------------------------------------------------------------------
// rfw_isqrt
// Digit-by-digit floor integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rfw_isqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rfw_pkg::ISQ_RAD_W-1:0]     radicand,
    output logic                              done,
    output logic [rfw_pkg::ISQ_ROOT_W-1:0]    root
);

    logic                               busy_reg,  busy_next;
    logic                               done_reg,  done_next;
    logic [4:0]                         cnt_reg,   cnt_next;
    logic [rfw_pkg::ISQ_RAD_W-1:0]      v_reg,     v_next;
    logic [rfw_pkg::ISQ_ROOT_W+1:0]     rem_reg,   rem_next;
    logic [rfw_pkg::ISQ_ROOT_W-1:0]     root_reg,  root_next;

    logic [rfw_pkg::ISQ_ROOT_W+3:0]     rem_sh;
    logic [rfw_pkg::ISQ_ROOT_W+3:0]     trial;
    logic                               ge;

    assign rem_sh = {rem_reg, v_reg[rfw_pkg::ISQ_RAD_W-1:rfw_pkg::ISQ_RAD_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below 2*root+1, so the truncation is safe
            rem_next  = ge ? (rfw_pkg::ISQ_ROOT_W+2)'(rem_sh - trial)
                           : (rfw_pkg::ISQ_ROOT_W+2)'(rem_sh);
            root_next = {root_reg[rfw_pkg::ISQ_ROOT_W-2:0], ge};
            v_next    = {v_reg[rfw_pkg::ISQ_RAD_W-3:0], 2'b00};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'(rfw_pkg::ISQ_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire
